// File: design/fsd_pkg.sv
// shared types and constants for the frame deframer
package fsd_pkg;

    localparam int unsigned HDR_LEN = 6;

    typedef logic [2:0] t_hdr_pos;

    localparam t_hdr_pos POS_MARKER = 3'd0;
    localparam t_hdr_pos POS_TYPE   = 3'd1;
    localparam t_hdr_pos POS_LEN_HI = 3'd4;
    localparam t_hdr_pos POS_LEN_LO = 3'd5;
    localparam t_hdr_pos POS_LIMIT  = 3'(HDR_LEN);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        logic       last_of_frame;
        logic       empty_frame;
    } t_result;

endpackage

// File: design/fsd_parse.sv
// header parser and payload counter for one byte per transfer
module fsd_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_res_valid,
    output fsd_pkg::t_result o_res
);
    import fsd_pkg::*;

    t_hdr_pos    r_pos;
    t_hdr_pos    n_pos;
    t_hdr_pos    pos;
    logic [7:0]  r_type;
    logic [7:0]  n_type;
    logic [7:0]  r_len_hi;
    logic [7:0]  n_len_hi;
    logic [15:0] r_remain;
    logic [15:0] n_remain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_MARKER;
            r_type   <= 8'd0;
            r_len_hi <= 8'd0;
            r_remain <= 16'd0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_len_hi <= n_len_hi;
            r_remain <= n_remain;
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_type      = r_type;
        n_len_hi    = r_len_hi;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '0;
        pos         = (r_pos >= POS_LIMIT) ? POS_MARKER : r_pos;
        if (r_remain != 16'd0) begin
            n_remain            = r_remain - 16'd1;
            o_res_valid         = 1'b1;
            o_res.payload_byte  = i_byte;
            o_res.frame_type    = r_type;
            o_res.last_of_frame = (n_remain == 16'd0);
        end else begin
            n_pos = pos + 3'd1;
            case (pos)
                POS_TYPE: begin
                    n_type = i_byte;
                end
                POS_LEN_HI: begin
                    n_len_hi = i_byte;
                end
                POS_LEN_LO: begin
                    n_pos    = POS_MARKER;
                    n_remain = {r_len_hi, i_byte};
                    if (n_remain == 16'd0) begin
                        o_res_valid         = 1'b1;
                        o_res.frame_type    = r_type;
                        o_res.last_of_frame = 1'b1;
                        o_res.empty_frame   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // empty mark only ever comes from the length byte
    a_empty_from_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res_valid && o_res.empty_frame |-> r_remain == 16'd0 && pos == POS_LEN_LO)
        else $error("empty mark outside length byte");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res_valid && o_res.last_of_frame |=> r_remain == 16'd0 && r_pos == POS_MARKER)
        else $error("counter not idle after last of frame");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_LIMIT)
        else $error("header position out of range");

endmodule

// File: design/flap_stream_deframer.sv
// top level: input register, parser and result register of the deframer
// path: an input transfer is held in the input register, then parsed, and its result is registered for o_out_valid
// throughput: one byte per cycle while results are not stalled; one byte held at the input while a result is stalled
// a result per payload byte, one per zero-length frame, none for other header bytes
// reset: synchronous, active low; clears handshake state, header position and counters
module flap_stream_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_frame_type,
    output logic       o_last_of_frame,
    output logic       o_empty_frame
);
    import fsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    fsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_frame_type    = r_out.frame_type;
    assign o_last_of_frame = r_out.last_of_frame;
    assign o_empty_frame   = r_out.empty_frame;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_frame |-> o_last_of_frame && o_payload_byte == 8'd0)
        else $error("empty mark without last or with data");
    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost");
    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_in_valid)
        else $error("input transfer not registered");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !step)
        else $error("stalled result overwritten");

endmodule

// File: tb/sv/tb_flap_stream_deframer.sv
// testbench for the frame deframer: directed and random framed byte streams checked against a predictor
`timescale 1ns / 100ps

module tb_flap_stream_deframer;

    import fsd_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_BYTES    = 1400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    class deframe_scoreboard;
        t_result     pending_results[$];
        t_hdr_pos    hdr_pos    = POS_MARKER;
        logic [7:0]  held_type  = 8'h00;
        logic [7:0]  len_high   = 8'h00;
        logic [15:0] bytes_left = 16'h0000;
        int          errors     = 0;
        int          bytes_in   = 0;
        int          results_ok = 0;
        int          frames     = 0;
        int          empties    = 0;

        // works out the result, if any, that one accepted byte causes
        function void note_byte(input logic [7:0] b);
            t_hdr_pos pos;
            t_result  res;
            bytes_in++;
            if (bytes_left != 16'h0000) begin
                bytes_left--;
                res.payload_byte  = b;
                res.frame_type    = held_type;
                res.last_of_frame = (bytes_left == 16'h0000);
                res.empty_frame   = 1'b0;
                pending_results = {pending_results, res};
                return;
            end
            pos = (hdr_pos >= POS_LIMIT) ? POS_MARKER : hdr_pos;
            case (pos)
                POS_TYPE: begin
                    held_type = b;
                end
                POS_LEN_HI: begin
                    len_high = b;
                end
                POS_LEN_LO: begin
                    hdr_pos    = POS_MARKER;
                    bytes_left = {len_high, b};
                    frames++;
                    if (bytes_left == 16'h0000) begin
                        empties++;
                        res.payload_byte  = 8'h00;
                        res.frame_type    = held_type;
                        res.last_of_frame = 1'b1;
                        res.empty_frame   = 1'b1;
                        pending_results = {pending_results, res};
                    end
                    return;
                end
                default: begin
                end
            endcase
            hdr_pos = t_hdr_pos'(pos + 3'd1);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: payload_byte %0h frame_type %0h",
                       got.payload_byte, got.frame_type);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0h, actual %0h",
                       want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.frame_type !== want.frame_type) begin
                $error("frame_type: expected %0h, actual %0h",
                       want.frame_type, got.frame_type);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0b, actual %0b",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
            if (got.empty_frame !== want.empty_frame) begin
                $error("empty_frame: expected %0b, actual %0b",
                       want.empty_frame, got.empty_frame);
                errors++;
            end
            results_ok++;
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_payload_byte;
    logic [7:0] o_frame_type;
    logic       o_last_of_frame;
    logic       o_empty_frame;

    deframe_scoreboard sb = new();

    bit      tx_burst       = 1'b0;
    bit      rx_burst       = 1'b0;
    bit      fast_mode      = 1'b0;
    int      rx_wait        = 0;
    int      hold_off_count = 0;
    int      hold_off_taken = 0;
    int      input_stalls   = 0;
    int      cycle_count    = 0;
    t_result rx_result;

    flap_stream_deframer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_frame_type    (o_frame_type),
        .o_last_of_frame (o_last_of_frame),
        .o_empty_frame   (o_empty_frame)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // result side: check each transfer, then draw the wait before the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                rx_result.payload_byte  = o_payload_byte;
                rx_result.frame_type    = o_frame_type;
                rx_result.last_of_frame = o_last_of_frame;
                rx_result.empty_frame   = o_empty_frame;
                sb.check_result(rx_result);
                if ($urandom_range(0, 39) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_wait = (rx_burst || fast_mode) ? 0 : $urandom_range(0, 15);
            end
            if (hold_off_count != hold_off_taken) begin
                hold_off_taken = hold_off_count;
                rx_wait        = HOLD_OFF_CYCLES;
            end
            if (o_in_stall && i_in_valid) begin
                input_stalls++;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_flap_stream_deframer failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (fast_mode || tx_burst) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len);
        tx_burst = ($urandom_range(0, 3) == 0);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(ftype);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int k = 0; k < int'(len); k++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int          nframe;
        int          pick;
        logic [15:0] len;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty frame with an all-zero header
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        // all-ones header bytes apart from the length, one payload byte
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hFF);
        // two payload bytes at the low and mid extremes
        send_byte(8'h5A); send_byte(8'h81); send_byte(8'h12);
        send_byte(8'h34); send_byte(8'h00); send_byte(8'h02);
        send_byte(8'h00); send_byte(8'h80);
        wait_results_drained();

        nframe = 0;
        while (sb.bytes_in < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                len = 16'd0;
            end else if (pick < 80) begin
                len = 16'($urandom_range(1, 16));
            end else if (pick < 95) begin
                len = 16'($urandom_range(17, 200));
            end else begin
                len = 16'($urandom_range(256, 511));
            end
            if (nframe == 3) begin
                // long hold-off on the result side while bytes keep coming
                hold_off_count <= hold_off_count + 1;
                len = 16'd48;
            end
            send_frame(8'($urandom_range(0, 255)), len);
            nframe++;
            if (nframe % 12 == 0) begin
                wait_results_drained();
            end
        end

        // length with a zero low byte, streamed without idling on either side
        wait_results_drained();
        fast_mode = 1'b1;
        send_frame(8'($urandom_range(0, 255)), 16'h0100);
        fast_mode = 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d frames (%0d empty), %0d results checked",
                 sb.bytes_in, sb.frames, sb.empties, sb.results_ok);
        $display("input held back on %0d cycles, one 256-byte frame sent with no idling",
                 input_stalls);
        if (sb.errors == 0) begin
            $display("tb_flap_stream_deframer passed");
        end else begin
            $display("tb_flap_stream_deframer failed");
        end
        $finish;
    end

endmodule
